/* src/rrs_pkg.sv */
// Shared types and constants for the rolling regression slope unit.
// No dependencies.
package rrs_pkg;

   localparam int WINDOW_MAX  = 32;
   localparam int SAMPLE_W    = 32;
   localparam int LEN_W       = 6;
   localparam int CNT_W       = $clog2(WINDOW_MAX);
   localparam int FILL_W      = $clog2(WINDOW_MAX + 1);
   localparam int WEIGHT_W    = 8;
   localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
   localparam int ACC_W       = 42;
   localparam int MAG_W       = ACC_W - 1;
   localparam int NSQ_W       = 11;
   localparam int DEN_W       = 15;
   localparam int DIVISOR_W   = DEN_W + 1;
   localparam int DIVIDEND_W  = MAG_W + 4;
   localparam int DIV_STEP_W  = $clog2(DIVIDEND_W + 1);

   localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(WINDOW_MAX);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(14);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

endpackage

/* src/rrs_cell.sv */
// One stage of the sample chain: holds one sample, loads from its upstream
// neighbor on a shift and from its downstream neighbor on a rotate.
// Depends on rrs_pkg.
module rrs_cell import rrs_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  sample_type    left_data,
   input  sample_type    right_data,
   output sample_type    data
);

   sample_type data_ff;
   sample_type data_in;

   always_comb begin
      if (ctrl.shift) begin
         data_in = left_data;
      end else if (ctrl.rotate) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* src/rrs_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rrs_pkg.
module rrs_div import rrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    diff;

   assign rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_W'(DIVIDEND_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         step_in = step_ff - DIV_STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/rolling_regression_slope_unit.sv */
// Rolling least-squares slope over the newest N Q16.16 samples of a series.
// Depends on rrs_pkg, rrs_cell, rrs_div.
//
// Usage:
//   req_* carries one sample per transfer (value, valid flag, series start);
//   rsp_* returns exactly one result per sample (slope, slope valid flag).
//   csr_* writes the window length N (2..32, values outside are clamped);
//   write it only while no sample is in flight. csr_ready is always high.
// Timing:
//   One sample is processed at a time; req_stall is high while it is.
//   A sample that gives no slope (leading invalid or window not yet full)
//   is offered on rsp after passing through S_EMIT. A slope takes 32
//   rotation steps of the sample chain feeding one multiply-accumulate,
//   S_PREP1 and S_PREP2, a 45-step bit-serial rounding divider and S_EMIT.
// Reset:
//   Clears the series state, sets N to 14 and empties the output register.
// Stall:
//   The result waits in the output register under rsp_stall; the next
//   sample is still taken and processed, and waits in turn for the register.
module rolling_regression_slope_unit import rrs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_sample_value,
   input  logic                 req_sample_valid,
   input  logic                 req_series_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_slope_value,
   output logic                 rsp_slope_valid,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LEN_W-1:0]     csr_window_length
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROT   = 3'd1;
   localparam logic [2:0] S_PREP1 = 3'd2;
   localparam logic [2:0] S_PREP2 = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   localparam logic [CNT_W-1:0]      ROT_LAST = CNT_W'(WINDOW_MAX - 1);
   localparam logic [FILL_W-1:0]     FILL_MAX = FILL_W'(WINDOW_MAX);
   localparam logic [DIVIDEND_W-1:0] SAT_MAG  = DIVIDEND_W'(64'h8000_0000);
   localparam logic [31:0]           POS_MAX  = 32'h7FFF_FFFF;

   logic [2:0]        state_ff, state_in;
   logic [LEN_W-1:0]  win_len_ff, win_len_in;
   logic [FILL_W-1:0] filled_ff, filled_in;
   logic              seen_ff, seen_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [NSQ_W-1:0]  nsq_ff, nsq_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  rot_cnt_ff, rot_cnt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [31:0]       res_value_ff, res_value_in;
   logic              res_valid_ff, res_valid_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic              rsp_sv_ff, rsp_sv_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic              out_free;
   logic [FILL_W-1:0] filled_eff;
   logic [FILL_W-1:0] filled_next;
   logic              seen_eff;
   logic [LEN_W-1:0]  n_clamped;
   logic              store;
   logic signed [WEIGHT_W-1:0] weight;
   logic signed [PROD_W-1:0]   prod;
   logic [ACC_W-1:0]  acc_abs;
   logic [2*LEN_W-1:0]       nsq_full;
   logic [LEN_W+NSQ_W-1:0]   den_full;
   logic              div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic              div_done;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic [31:0]       q_sat;

   cell_ctrl_type     cell_ctrl;
   sample_type        win_data  [WINDOW_MAX];
   sample_type        left_bus  [WINDOW_MAX];
   sample_type        right_bus [WINDOW_MAX];

   // sample chain
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_bus[i] = req_sample_value;
      end else begin : g_body
         assign left_bus[i] = win_data[i-1];
      end
      assign right_bus[i] = win_data[(i + 1) % WINDOW_MAX];

      rrs_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .left_data  (left_bus[i]),
         .right_data (right_bus[i]),
         .data       (win_data[i])
      );
   end

   rrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign filled_eff  = req_series_start ? '0 : filled_ff;
   assign seen_eff    = req_series_start ? 1'b0 : seen_ff;
   assign store       = req_sample_valid || seen_eff;
   assign filled_next = (filled_eff < FILL_MAX) ? filled_eff + FILL_W'(1) : filled_eff;

   always_comb begin
      if (win_len_ff < LEN_MIN) begin
         n_clamped = LEN_MIN;
      end else if (win_len_ff > LEN_MAX) begin
         n_clamped = LEN_MAX;
      end else begin
         n_clamped = win_len_ff;
      end
   end

   assign cell_ctrl.shift  = accept && store;
   assign cell_ctrl.rotate = (state_ff == S_ROT);

   // weight of the sample at chain head: N-1-2j
   assign weight   = WEIGHT_W'(n_ff) - WEIGHT_W'(1) - (WEIGHT_W'(rot_cnt_ff) << 1);
   assign prod     = win_data[0] * weight;
   assign nsq_full = n_clamped * n_clamped;
   assign den_full = n_ff * (nsq_ff - NSQ_W'(1));
   assign acc_abs  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   // rounding: (2*6*|acc| + den) / (2*den)
   assign div_start    = (state_ff == S_PREP2);
   assign div_dividend = {1'b0, mag_ff, 3'b000} + {2'b00, mag_ff, 2'b00}
                         + DIVIDEND_W'(den_ff);
   assign div_divisor  = {den_ff, 1'b0};

   assign q_sat = (div_quotient > SAT_MAG) ? SAT_MAG[31:0] : div_quotient[31:0];

   always_comb begin
      state_in     = state_ff;
      win_len_in   = win_len_ff;
      filled_in    = filled_ff;
      seen_in      = seen_ff;
      n_in         = n_ff;
      nsq_in       = nsq_ff;
      den_in       = den_ff;
      rot_cnt_in   = rot_cnt_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      res_value_in = res_value_ff;
      res_valid_in = res_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         win_len_in = csr_window_length;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               filled_in    = filled_eff;
               seen_in      = seen_eff;
               res_value_in = '0;
               res_valid_in = 1'b0;
               state_in     = S_EMIT;
               if (store) begin
                  filled_in  = filled_next;
                  seen_in    = 1'b1;
                  n_in       = n_clamped;
                  nsq_in     = nsq_full[NSQ_W-1:0];
                  rot_cnt_in = '0;
                  acc_in     = '0;
                  if (filled_next >= FILL_W'(n_clamped)) begin
                     state_in = S_ROT;
                  end
               end
            end
         end
         S_ROT: begin
            if (LEN_W'(rot_cnt_ff) < n_ff) begin
               acc_in = acc_ff + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            end
            if (rot_cnt_ff == '0) begin
               den_in = den_full[DEN_W-1:0];
            end
            rot_cnt_in = rot_cnt_ff + CNT_W'(1);
            if (rot_cnt_ff == ROT_LAST) begin
               state_in = S_PREP1;
            end
         end
         S_PREP1: begin
            neg_in   = acc_ff[ACC_W-1];
            mag_in   = acc_abs[MAG_W-1:0];
            state_in = S_PREP2;
         end
         S_PREP2: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_valid_in = 1'b1;
               if (neg_ff) begin
                  res_value_in = -q_sat;
               end else if (q_sat > POS_MAX) begin
                  res_value_in = POS_MAX;
               end else begin
                  res_value_in = q_sat;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_value_in = res_value_ff;
               rsp_sv_in    = res_valid_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_len_ff   <= LEN_RESET;
         filled_ff    <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_len_ff   <= win_len_in;
         filled_ff    <= filled_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      nsq_ff       <= nsq_in;
      den_ff       <= den_in;
      rot_cnt_ff   <= rot_cnt_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      res_value_ff <= res_value_in;
      res_valid_ff <= res_valid_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sv_ff    <= rsp_sv_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slope_value = rsp_value_ff;
   assign rsp_slope_valid = rsp_sv_ff;

   a_fill_needs_seen: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> filled_ff == '0)
      else $error("samples held before first valid sample");

   a_rot_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT && rot_cnt_ff == ROT_LAST) |=> state_ff == S_PREP1)
      else $error("chain rotation did not complete in one pass");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide phase");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("output register loaded without a pending result");

endmodule
